/* rtl/jsesc_pkg.sv */
// Package for the JSON string escaper: beat types, mode codes and character constants.
package jsesc_pkg;

  localparam logic [1:0] MODE_DATA  = 2'd0;
  localparam logic [1:0] MODE_START = 2'd1;
  localparam logic [1:0] MODE_END   = 2'd2;

  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5c;
  localparam logic [7:0] CH_LOWER_U   = 8'h75;
  localparam logic [7:0] CH_ZERO      = 8'h30;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_BS        = 8'h08;
  localparam logic [7:0] CH_FF        = 8'h0c;
  localparam logic [7:0] CH_LF        = 8'h0a;
  localparam logic [7:0] CH_CR        = 8'h0d;
  localparam logic [7:0] CH_TAB       = 8'h09;

  localparam logic [7:0] LEAD_MIN     = 8'hc2;
  localparam logic [7:0] LEAD_TWO_MAX = 8'hdf;
  localparam logic [7:0] LEAD_THR_MAX = 8'hef;
  localparam logic [7:0] LEAD_MAX     = 8'hf4;
  localparam logic [7:0] LEAD_E0      = 8'he0;
  localparam logic [7:0] LEAD_ED      = 8'hed;
  localparam logic [7:0] LEAD_F0      = 8'hf0;
  localparam logic [7:0] LEAD_F4      = 8'hf4;
  localparam logic [7:0] CONT_MIN     = 8'h80;
  localparam logic [7:0] CONT_MAX     = 8'hbf;
  localparam logic [7:0] CONT_E0_MIN  = 8'ha0;
  localparam logic [7:0] CONT_ED_MAX  = 8'h9f;
  localparam logic [7:0] CONT_F0_MIN  = 8'h90;
  localparam logic [7:0] CONT_F4_MAX  = 8'h8f;

  localparam logic [2:0] HEX_LAST = 3'd5;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] data_byte;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
  } out_beat_t;

  // Lowercase ASCII hex digit for one nibble.
  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    logic [7:0] r;
    if (nib < 4'd10) begin
      r = 8'h30 + {4'd0, nib};
    end else begin
      r = 8'h57 + {4'd0, nib};
    end
    return r;
  endfunction

endpackage

/* rtl/json_string_escaper_utf8_check.sv */
// JSON string escaper with strict UTF-8 sequence checking, byte-serial sequencer.
//
//   channel | direction | handshake            | beat
//   in      | input     | in_valid_i/in_stall_o | in_beat_t  (mode, data_byte)
//   out     | output    | out_valid_o/out_stall_i | out_beat_t (out_byte, last_of_run)
//
// One output character is produced per cycle, while the output is not stalled, by
// a single character selector under a small sequencer; an input beat emits up to
// 24 characters, and its byte emits nothing when it ends up held as a new lead byte.
// A continuation byte that is only stored emits nothing.
// The input is stalled while a beat is being expanded; an output stall holds
// the sequencer. Reset clears the sequencer, the held-byte count and the output valid flag.
module json_string_escaper_utf8_check
  import jsesc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_beat_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_beat_t out_data_o
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_FLUSH = 5'b00010,
    ST_FRESH = 5'b00100,
    ST_COPY  = 5'b01000,
    ST_QUOTE = 5'b10000
  } state_e;

  state_e     state_q;
  logic [1:0] cnt_q;
  logic [2:0] exp_q;
  logic [1:0] idx_q;
  logic [2:0] char_q;
  logic       do_quote_q;
  logic       out_valid_q;
  logic [7:0] held_q [3];
  logic [7:0] byte_q;
  out_beat_t  out_q;

  logic       accept;
  logic       adv;
  logic [7:0] in_b;
  logic       cont_ok;
  logic       seq_done;
  logic [7:0] held_rd;
  logic [7:0] hex_src;
  logic [7:0] hex_char;
  logic       f_two;
  logic       f_lead;
  logic       f_hex;
  logic [7:0] f_sym;
  logic [2:0] lead_len;
  logic       flush_end;
  logic       emit;
  logic [7:0] char_d;
  logic       last_d;
  logic [7:0] lo;
  logic [7:0] hi;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign adv         = !out_valid_q || !out_stall_i;
  assign in_b        = in_data_i.data_byte;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Strict range for the next continuation byte.
  always_comb begin
    lo = CONT_MIN;
    hi = CONT_MAX;
    if (cnt_q == 2'd1) begin
      case (held_q[0])
        LEAD_E0: lo = CONT_E0_MIN;
        LEAD_ED: hi = CONT_ED_MAX;
        LEAD_F0: lo = CONT_F0_MIN;
        LEAD_F4: hi = CONT_F4_MAX;
        default: ;
      endcase
    end
  end
  assign cont_ok  = (in_b >= lo) && (in_b <= hi);
  assign seq_done = ({1'b0, cnt_q} + 3'd1) >= exp_q;

  always_comb begin
    case (idx_q)
      2'd0:    held_rd = held_q[0];
      2'd1:    held_rd = held_q[1];
      default: held_rd = held_q[2];
    endcase
  end

  // Classify the latched byte as handled on its own.
  always_comb begin
    f_two = 1'b1;
    f_sym = byte_q;
    case (byte_q)
      CH_QUOTE:     f_sym = CH_QUOTE;
      CH_BACKSLASH: f_sym = CH_BACKSLASH;
      CH_BS:        f_sym = 8'h62;
      CH_FF:        f_sym = 8'h66;
      CH_LF:        f_sym = 8'h6e;
      CH_CR:        f_sym = 8'h72;
      CH_TAB:       f_sym = 8'h74;
      default:      f_two = 1'b0;
    endcase
  end
  assign f_lead   = (byte_q >= LEAD_MIN) && (byte_q <= LEAD_MAX);
  assign f_hex    = !f_two && !f_lead && ((byte_q < CH_SPACE) || (byte_q >= CONT_MIN));
  assign lead_len = (byte_q <= LEAD_TWO_MAX) ? 3'd2 : ((byte_q <= LEAD_THR_MAX) ? 3'd3 : 3'd4);

  // Shared \u00xx character generator.
  assign hex_src = (state_q == ST_FLUSH) ? held_rd : byte_q;
  always_comb begin
    case (char_q)
      3'd0:    hex_char = CH_BACKSLASH;
      3'd1:    hex_char = CH_LOWER_U;
      3'd2:    hex_char = CH_ZERO;
      3'd3:    hex_char = CH_ZERO;
      3'd4:    hex_char = hex_digit(hex_src[7:4]);
      default: hex_char = hex_digit(hex_src[3:0]);
    endcase
  end

  assign flush_end = (char_q == HEX_LAST) && (idx_q == (cnt_q - 2'd1));

  always_comb begin
    emit   = 1'b0;
    char_d = hex_char;
    last_d = 1'b0;
    case (state_q)
      ST_FLUSH: begin
        emit   = adv;
        last_d = flush_end && !do_quote_q && f_lead;
      end
      ST_FRESH: begin
        emit = adv && !f_lead;
        if (f_two) begin
          char_d = (char_q == 3'd0) ? CH_BACKSLASH : f_sym;
          last_d = (char_q != 3'd0);
        end else if (f_hex) begin
          last_d = (char_q == HEX_LAST);
        end else begin
          char_d = byte_q;
          last_d = 1'b1;
        end
      end
      ST_COPY: begin
        emit   = adv;
        char_d = (idx_q == cnt_q) ? byte_q : held_rd;
        last_d = (idx_q == cnt_q);
      end
      ST_QUOTE: begin
        emit   = adv;
        char_d = CH_QUOTE;
        last_d = 1'b1;
      end
      default: ;
    endcase
  end

  // The last flag of a flush is only set when the failing byte is a new lead
  // byte, which is held and emits nothing; otherwise its own output or the
  // closing quote ends the run.

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= 2'd0;
      exp_q       <= 3'd0;
      idx_q       <= 2'd0;
      char_q      <= 3'd0;
      do_quote_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end
      case (state_q)
        ST_IDLE: begin
          idx_q  <= 2'd0;
          char_q <= 3'd0;
          if (accept) begin
            case (in_data_i.mode)
              MODE_DATA: begin
                if (cnt_q == 2'd0) begin
                  state_q <= ST_FRESH;
                end else if (!cont_ok) begin
                  do_quote_q <= 1'b0;
                  state_q    <= ST_FLUSH;
                end else if (seq_done) begin
                  state_q <= ST_COPY;
                end else begin
                  cnt_q <= cnt_q + 2'd1;
                end
              end
              MODE_START: begin
                cnt_q   <= 2'd0;
                exp_q   <= 3'd0;
                state_q <= ST_QUOTE;
              end
              MODE_END: begin
                if (cnt_q != 2'd0) begin
                  do_quote_q <= 1'b1;
                  state_q    <= ST_FLUSH;
                end else begin
                  state_q <= ST_QUOTE;
                end
              end
              default: ;
            endcase
          end
        end
        ST_FLUSH: begin
          if (adv) begin
            if (char_q == HEX_LAST) begin
              char_q <= 3'd0;
              if (flush_end) begin
                cnt_q   <= 2'd0;
                exp_q   <= 3'd0;
                state_q <= do_quote_q ? ST_QUOTE : ST_FRESH;
              end else begin
                idx_q <= idx_q + 2'd1;
              end
            end else begin
              char_q <= char_q + 3'd1;
            end
          end
        end
        ST_FRESH: begin
          if (f_lead) begin
            cnt_q   <= 2'd1;
            exp_q   <= lead_len;
            state_q <= ST_IDLE;
          end else if (adv) begin
            if (last_d) begin
              state_q <= ST_IDLE;
            end else begin
              char_q <= char_q + 3'd1;
            end
          end
        end
        ST_COPY: begin
          if (adv) begin
            if (idx_q == cnt_q) begin
              cnt_q   <= 2'd0;
              exp_q   <= 3'd0;
              state_q <= ST_IDLE;
            end else begin
              idx_q <= idx_q + 2'd1;
            end
          end
        end
        ST_QUOTE: begin
          if (adv) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q <= in_b;
      if (in_data_i.mode == MODE_DATA && cnt_q != 2'd0 && cont_ok && !seq_done) begin
        held_q[cnt_q] <= in_b;
      end
    end
    if (state_q == ST_FRESH && f_lead) begin
      held_q[0] <= byte_q;
    end
    if (emit) begin
      out_q.out_byte    <= char_d;
      out_q.last_of_run <= last_d;
    end
  end

`ifndef ASSERT_OFF
  a_held_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != 2'd0) |-> (exp_q >= 3'd2 && {1'b0, cnt_q} < exp_q))
    else $error("held count does not fit the expected sequence length");

  a_flush_has_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FLUSH) |-> (cnt_q != 2'd0 && idx_q < cnt_q))
    else $error("flush walks past the held bytes");

  a_copy_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_COPY) |-> (idx_q <= cnt_q && cnt_q != 2'd0))
    else $error("copy index out of range");

  a_char_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    char_q <= HEX_LAST)
    else $error("character counter out of range");

  a_hold_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> (out_valid_q && $stable(out_q)))
    else $error("stalled output beat changed");
`endif

endmodule
